>>> rtl/ppm_frame_decoder_unit_macros.svh
// Assertion macros shared by the PPM frame decoder RTL.
`ifndef PPM_FRAME_DECODER_UNIT_MACROS_SVH
`define PPM_FRAME_DECODER_UNIT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define PPM_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ppm decoder: invariant violated");

// The consequence holds in the same cycle as the antecedent.
`define PPM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppm decoder: implication violated");

// The consequence holds in the cycle after the antecedent.
`define PPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppm decoder: next-cycle implication violated");

`endif

>>> rtl/ppm_pkg.sv
// Types, constants and helper functions of the PPM frame decoder.
package ppm_pkg;

   // Default depth of the channel store.
   localparam int MAX_CHANNELS_DEF = 16;

   // Field widths.
   localparam int TIME_W     = 32;
   localparam int VALUE_W    = 16;
   localparam int CHAN_W     = 5;
   localparam int VEL_W      = 19;
   localparam int SPEED_W    = 7;
   localparam int IN_DATA_W  = 32;
   localparam int OUT_DATA_W = 72;

   // Configuration port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_MIN_WIDTH = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MAX_WIDTH = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_MAX_VEL   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CHAN_CNT  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TRIGGER   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_MOTOR_THR = 3'd5;

   // Register reset values.
   localparam logic [VALUE_W-1:0] MIN_WIDTH_RST = 16'd1000;
   localparam logic [VALUE_W-1:0] MAX_WIDTH_RST = 16'd2000;
   localparam logic [VALUE_W-1:0] MAX_VEL_RST   = 16'd0;
   localparam logic [CHAN_W-1:0]  CHAN_CNT_RST  = 5'd8;
   localparam logic               TRIGGER_RST   = 1'b1;
   localparam logic [VALUE_W-1:0] MOTOR_THR_RST = 16'd0;

   // Q2.14 levels.
   localparam int                 Q_FRAC     = 14;
   localparam logic [VALUE_W-1:0] Q_HALF     = 16'd8192;
   localparam logic [VALUE_W-1:0] SYNC_LEVEL = 16'd19661;
   localparam logic [VALUE_W-1:0] VALUE_SAT  = 16'hFFFF;

   // Serial divider: the scaled interval below saturation fits in 18 bits.
   localparam int DIV_IN_W = 18;
   localparam int DIV_CNT_W = 4;

   // Velocity arithmetic.
   localparam int DEV_W  = 18;
   localparam int PROD_W = 35;
   localparam logic signed [DEV_W-1:0] DEV_OFFSET = 18'sd32768;
   localparam logic signed [PROD_W-1:0] TRUNC_BIAS = 35'sd16383;

   // Speed arithmetic.
   localparam int SPEED_PROD_W = 23;
   localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;
   localparam logic [CHAN_W-1:0]  SPEED_MIN_CHANNELS = 5'd6;

   // Read-back sequence of the channel store after a sync gap.
   localparam int STEP_W      = 3;
   localparam int READ_STEPS  = 5;
   localparam int DRAIN_W     = 2;
   localparam int DRAIN_CYCLES = 3;

   typedef enum logic [2:0] {
      SEL_ROT,
      SEL_LIN,
      SEL_AUTO,
      SEL_MOTOR,
      SEL_SPEED
   } held_sel_type;

   // Command that travels with each channel store read.
   typedef struct packed {
      logic         valid;
      held_sel_type sel;
   } held_cmd_type;

   // Channel store entry read at each step (velocities first).
   function automatic logic [2:0] step_addr(input logic [STEP_W-1:0] step);
      logic [2:0] addr;
      case (step)
         3'd0:    addr = 3'd0;
         3'd1:    addr = 3'd1;
         3'd2:    addr = 3'd4;
         3'd3:    addr = 3'd5;
         3'd4:    addr = 3'd6;
         default: addr = 3'd0;
      endcase
      return addr;
   endfunction

   // Held output that each step refreshes.
   function automatic held_sel_type step_sel(input logic [STEP_W-1:0] step);
      held_sel_type sel;
      case (step)
         3'd0:    sel = SEL_ROT;
         3'd1:    sel = SEL_LIN;
         3'd2:    sel = SEL_AUTO;
         3'd3:    sel = SEL_MOTOR;
         3'd4:    sel = SEL_SPEED;
         default: sel = SEL_ROT;
      endcase
      return sel;
   endfunction

endpackage

>>> rtl/ppm_divider.sv
// Restoring serial divider that yields the 16-bit Q2.14 channel value.
module ppm_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ppm_pkg::DIV_IN_W-1:0] dividend,
   input  logic [ppm_pkg::VALUE_W-1:0]  divisor,
   output logic                         done,
   output logic [ppm_pkg::VALUE_W-1:0]  quotient
);
   import ppm_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [VALUE_W-1:0]   rem_ff;
   logic [VALUE_W-1:0]   bits_ff;
   logic [VALUE_W-1:0]   quo_ff;
   logic [VALUE_W-1:0]   div_ff;

   logic [VALUE_W:0]     trial;
   logic                 fits;
   logic [VALUE_W:0]     trial_sub;

   // One quotient bit per cycle; the remainder always stays below the divisor.
   always_comb begin
      trial     = {rem_ff, bits_ff[VALUE_W-1]};
      fits      = trial >= {1'b0, div_ff};
      trial_sub = trial - {1'b0, div_ff};
   end

   // Control of the iteration.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: the dividend, the interval above the minimum width, is shifted left by the fraction width.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= dividend[DIV_IN_W-1:DIV_IN_W-VALUE_W];
         bits_ff <= {dividend[DIV_IN_W-VALUE_W-1:0], {(VALUE_W-DIV_IN_W+VALUE_W){1'b0}}};
         quo_ff  <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= fits ? trial_sub[VALUE_W-1:0] : trial[VALUE_W-1:0];
         bits_ff <= {bits_ff[VALUE_W-2:0], 1'b0};
         quo_ff  <= {quo_ff[VALUE_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/ppm_chan_mem.sv
// Channel store: a one-port-write, one-port-read memory with per-entry valid bits.
module ppm_chan_mem #(
   parameter int DEPTH = ppm_pkg::MAX_CHANNELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [ppm_pkg::VALUE_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [ppm_pkg::VALUE_W-1:0]  rd_data
);
   import ppm_pkg::*;

   logic [VALUE_W-1:0] store_ff [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [VALUE_W-1:0] rd_data_ff;
   logic               rd_valid_ff;

   // Memory array with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   // Entries never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> rtl/ppm_held.sv
// Held control outputs, refreshed from channel store reads after a sync gap.
module ppm_held (
   input  logic                               clock,
   input  logic                               reset,
   input  ppm_pkg::held_cmd_type              cmd,
   input  logic [ppm_pkg::VALUE_W-1:0]        rd_data,
   input  logic [ppm_pkg::VALUE_W-1:0]        max_velocity,
   input  logic [ppm_pkg::VALUE_W-1:0]        motor_threshold,
   input  logic [ppm_pkg::CHAN_W-1:0]         channel_count,
   output logic signed [ppm_pkg::VEL_W-1:0]   linear_velocity,
   output logic signed [ppm_pkg::VEL_W-1:0]   rotation_velocity,
   output logic                               auto_mode,
   output logic                               motor_on,
   output logic [ppm_pkg::SPEED_W-1:0]        speed_percent
);
   import ppm_pkg::*;

   logic signed [DEV_W-1:0]  dev;
   logic [SPEED_PROD_W-1:0]  speed_prod;
   logic [SPEED_PROD_W-Q_FRAC-1:0] speed_raw;
   logic [SPEED_W-1:0]       speed_clamped;
   logic                     vel_cmd;

   logic                     vel_a_ff;
   logic                     lin_a_ff;
   logic signed [DEV_W-1:0]  dev_ff;
   logic                     vel_b_ff;
   logic                     lin_b_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic signed [PROD_W-1:0] prod_biased;
   logic signed [PROD_W-1:0] vel_scaled;
   logic                     over_pos;
   logic                     over_neg;
   logic signed [VEL_W-1:0]  vel_clamped;

   logic signed [VEL_W-1:0]  held_lin_ff;
   logic signed [VEL_W-1:0]  held_rot_ff;
   logic                     held_auto_ff;
   logic                     held_motor_ff;
   logic [SPEED_W-1:0]       held_speed_ff;

   // Stick deviation 2v - 2.0 and the speed percent of the current read.
   always_comb begin
      dev           = $signed({1'b0, rd_data, 1'b0}) - DEV_OFFSET;
      speed_prod    = SPEED_PROD_W'(rd_data) * SPEED_PROD_W'(SPEED_MAX);
      speed_raw     = speed_prod[SPEED_PROD_W-1:Q_FRAC];
      speed_clamped = (speed_raw > (SPEED_PROD_W-Q_FRAC)'(SPEED_MAX))
                      ? SPEED_MAX : speed_raw[SPEED_W-1:0];
      vel_cmd       = cmd.valid && (cmd.sel == SEL_ROT || cmd.sel == SEL_LIN);
   end

   // Velocity pipeline: deviation, product, then scaling and clamping.
   always_ff @(posedge clock) begin
      if (reset) begin
         vel_a_ff <= 1'b0;
         vel_b_ff <= 1'b0;
      end else begin
         vel_a_ff <= vel_cmd;
         vel_b_ff <= vel_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      lin_a_ff <= (cmd.sel == SEL_LIN);
      dev_ff   <= dev;
      lin_b_ff <= lin_a_ff;
      prod_ff  <= dev_ff * $signed({1'b0, max_velocity});
   end

   // Division by 1.0 truncates toward zero, then the result is clamped to 19 bits.
   always_comb begin
      prod_biased = prod_ff + (prod_ff[PROD_W-1] ? TRUNC_BIAS : '0);
      vel_scaled  = prod_biased >>> Q_FRAC;
      over_pos    = !vel_scaled[PROD_W-1] && (vel_scaled[PROD_W-2:VEL_W-1] != '0);
      over_neg    = vel_scaled[PROD_W-1] && (vel_scaled[PROD_W-2:VEL_W-1] != '1);
      if (over_pos) begin
         vel_clamped = {1'b0, {(VEL_W-1){1'b1}}};
      end else if (over_neg) begin
         vel_clamped = {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
         vel_clamped = vel_scaled[VEL_W-1:0];
      end
   end

   // Held registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_lin_ff   <= '0;
         held_rot_ff   <= '0;
         held_auto_ff  <= 1'b0;
         held_motor_ff <= 1'b0;
         held_speed_ff <= '0;
      end else begin
         if (vel_b_ff) begin
            if (lin_b_ff) begin
               held_lin_ff <= vel_clamped;
            end else begin
               held_rot_ff <= vel_clamped;
            end
         end
         if (cmd.valid) begin
            case (cmd.sel)
               SEL_AUTO:  held_auto_ff  <= (rd_data >= Q_HALF);
               SEL_MOTOR: held_motor_ff <= (rd_data >= motor_threshold);
               SEL_SPEED: begin
                  if (channel_count > SPEED_MIN_CHANNELS) begin
                     held_speed_ff <= speed_clamped;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   assign linear_velocity   = held_lin_ff;
   assign rotation_velocity = held_rot_ff;
   assign auto_mode         = held_auto_ff;
   assign motor_on          = held_motor_ff;
   assign speed_percent     = held_speed_ff;

endmodule

>>> rtl/ppm_frame_decoder_unit.sv
// Top level of the PPM frame decoder: sequencer, configuration registers, output stage.
//
//   Channel   Direction  Ports                     Contents
//   req_      in         tvalid tready tdata tuser pin edge: time stamp, pin level
//   rsp_      out        tvalid tready tdata tlast channel value and held controls
//   csr_      in/out     APB psel penable ...      six configuration registers
//
// An edge at the other level is dropped; the first kept edge only records its time stamp.
// A pulse passes the prepare, check, divide, write and emit states, the divide state
// waiting on the 16-step serial divider; values below the minimum or saturated skip it.
// A sync gap adds read and drain states that read channels back from the channel store.
// Reset is synchronous; the store uses valid bits and needs no clearing pass.
// A waiting request is accepted while the previous result sits in the output register.
`include "ppm_frame_decoder_unit_macros.svh"

module ppm_frame_decoder_unit #(
   parameter int MAX_CHANNELS = ppm_pkg::MAX_CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: time_us[31:0]
   input  logic [ppm_pkg::IN_DATA_W-1:0]       req_tdata,
   // tuser: pin_level[0]
   input  logic                                req_tuser,
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: channel_index[4:0], channel_value[20:5], linear_velocity[39:21],
   //        rotation_velocity[58:40], auto_mode[59], motor_on[60],
   //        speed_percent[67:61], zero[71:68]
   output logic [ppm_pkg::OUT_DATA_W-1:0]      rsp_tdata,
   // tlast: frame_end
   output logic                                rsp_tlast,
   // Configuration port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ppm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ppm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ppm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import ppm_pkg::*;

   localparam int PCW = $clog2(MAX_CHANNELS + 1);
   localparam int AW  = $clog2(MAX_CHANNELS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_CHECK,
      ST_DIVIDE,
      ST_WRITE,
      ST_READ,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // Configuration registers.
   logic [VALUE_W-1:0]   min_width_ff;
   logic [VALUE_W-1:0]   max_width_ff;
   logic [VALUE_W-1:0]   max_vel_ff;
   logic [CHAN_W-1:0]    chan_cnt_ff;
   logic                 trigger_ff;
   logic [VALUE_W-1:0]   motor_thr_ff;

   // Sequencer state.
   state_type            state_ff;
   logic [TIME_W-1:0]    last_time_ff;
   logic [PCW-1:0]       pulse_ff;
   logic [PCW-1:0]       ch_ff;
   logic [TIME_W-1:0]    interval_ff;
   logic [TIME_W-1:0]    diff_ff;
   logic [VALUE_W-1:0]   span_ff;
   logic                 below_ff;
   logic                 empty_ff;
   logic [VALUE_W-1:0]   val_ff;
   logic                 sync_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [DRAIN_W-1:0]   drain_ff;
   held_cmd_type         held_cmd_ff;

   // Output register.
   logic                 rsp_tvalid_ff;
   logic                 rsp_tlast_ff;
   logic [CHAN_W-1:0]    rsp_index_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic signed [VEL_W-1:0] rsp_lin_ff;
   logic signed [VEL_W-1:0] rsp_rot_ff;
   logic                 rsp_auto_ff;
   logic                 rsp_motor_ff;
   logic [SPEED_W-1:0]   rsp_speed_ff;

   logic                 csr_wr;
   logic [REG_IDX_W-1:0] csr_idx;
   logic                 out_free;
   logic                 saturated;
   logic                 div_start;
   logic                 div_done;
   logic [VALUE_W-1:0]   div_quotient;
   logic                 mem_wr_en;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [AW-1:0]        mem_rd_addr;
   logic [VALUE_W-1:0]   mem_rd_data;

   logic signed [VEL_W-1:0] held_lin;
   logic signed [VEL_W-1:0] held_rot;
   logic                 held_auto;
   logic                 held_motor;
   logic [SPEED_W-1:0]   held_speed;

   // Configuration port decode and read-back.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      case (csr_idx)
         REG_MIN_WIDTH: csr_prdata = CSR_DATA_W'(min_width_ff);
         REG_MAX_WIDTH: csr_prdata = CSR_DATA_W'(max_width_ff);
         REG_MAX_VEL:   csr_prdata = CSR_DATA_W'(max_vel_ff);
         REG_CHAN_CNT:  csr_prdata = CSR_DATA_W'(chan_cnt_ff);
         REG_TRIGGER:   csr_prdata = CSR_DATA_W'(trigger_ff);
         REG_MOTOR_THR: csr_prdata = CSR_DATA_W'(motor_thr_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff <= MIN_WIDTH_RST;
         max_width_ff <= MAX_WIDTH_RST;
         max_vel_ff   <= MAX_VEL_RST;
         chan_cnt_ff  <= CHAN_CNT_RST;
         trigger_ff   <= TRIGGER_RST;
         motor_thr_ff <= MOTOR_THR_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_MIN_WIDTH: min_width_ff <= csr_pwdata[VALUE_W-1:0];
            REG_MAX_WIDTH: max_width_ff <= csr_pwdata[VALUE_W-1:0];
            REG_MAX_VEL:   max_vel_ff   <= csr_pwdata[VALUE_W-1:0];
            REG_CHAN_CNT:  chan_cnt_ff  <= csr_pwdata[CHAN_W-1:0];
            REG_TRIGGER:   trigger_ff   <= csr_pwdata[0];
            REG_MOTOR_THR: motor_thr_ff <= csr_pwdata[VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake and sequencer decode.
   assign req_tready  = (state_ff == ST_IDLE) && !reset;
   assign out_free    = !rsp_tvalid_ff || rsp_tready;
   assign saturated   = diff_ff >= TIME_W'({span_ff, 2'b00});
   assign div_start   = (state_ff == ST_CHECK) && !below_ff && !empty_ff && !saturated;
   assign mem_wr_en   = (state_ff == ST_WRITE);
   assign mem_wr_addr = AW'(ch_ff - 1'b1);
   assign mem_rd_en   = (state_ff == ST_READ);
   assign mem_rd_addr = AW'(step_addr(step_ff));

   // Sequencer: measure, normalise, store, refresh held outputs on a sync gap, and emit the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_time_ff  <= '0;
         pulse_ff      <= '0;
         step_ff       <= '0;
         drain_ff      <= '0;
         held_cmd_ff   <= '{valid: 1'b0, sel: SEL_ROT};
         rsp_tvalid_ff <= 1'b0;
      end else begin
         held_cmd_ff.valid <= 1'b0;
         if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tuser == trigger_ff) begin
                  last_time_ff <= req_tdata;
                  if (pulse_ff == '0) begin
                     pulse_ff <= PCW'(1);
                  end else begin
                     ch_ff       <= pulse_ff;
                     interval_ff <= req_tdata - last_time_ff;
                     state_ff    <= ST_PREP;
                  end
               end
            end
            ST_PREP: begin
               diff_ff  <= interval_ff - TIME_W'(min_width_ff);
               below_ff <= interval_ff < TIME_W'(min_width_ff);
               empty_ff <= max_width_ff <= min_width_ff;
               span_ff  <= max_width_ff - min_width_ff;
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (below_ff) begin
                  val_ff   <= '0;
                  state_ff <= ST_WRITE;
               end else if (empty_ff || saturated) begin
                  val_ff   <= VALUE_SAT;
                  state_ff <= ST_WRITE;
               end else begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  val_ff   <= div_quotient;
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               sync_ff <= val_ff >= SYNC_LEVEL;
               if (val_ff >= SYNC_LEVEL) begin
                  pulse_ff <= PCW'(1);
                  step_ff  <= '0;
                  state_ff <= ST_READ;
               end else begin
                  if (pulse_ff < PCW'(MAX_CHANNELS)) begin
                     pulse_ff <= pulse_ff + 1'b1;
                  end
                  state_ff <= ST_EMIT;
               end
            end
            ST_READ: begin
               held_cmd_ff <= '{valid: 1'b1, sel: step_sel(step_ff)};
               if (step_ff == STEP_W'(READ_STEPS - 1)) begin
                  drain_ff <= '0;
                  state_ff <= ST_DRAIN;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               if (drain_ff == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                  state_ff <= ST_EMIT;
               end else begin
                  drain_ff <= drain_ff + 1'b1;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tlast_ff  <= sync_ff;
                  rsp_index_ff  <= CHAN_W'(ch_ff);
                  rsp_value_ff  <= val_ff;
                  rsp_lin_ff    <= held_lin;
                  rsp_rot_ff    <= held_rot;
                  rsp_auto_ff   <= held_auto;
                  rsp_motor_ff  <= held_motor;
                  rsp_speed_ff  <= held_speed;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Serial divider for the normalised interval.
   ppm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff_ff[DIV_IN_W-1:0]),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Channel store.
   ppm_chan_mem #(
      .DEPTH (MAX_CHANNELS)
   ) u_chan_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (val_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Held control outputs.
   ppm_held u_held (
      .clock             (clock),
      .reset             (reset),
      .cmd               (held_cmd_ff),
      .rd_data           (mem_rd_data),
      .max_velocity      (max_vel_ff),
      .motor_threshold   (motor_thr_ff),
      .channel_count     (chan_cnt_ff),
      .linear_velocity   (held_lin),
      .rotation_velocity (held_rot),
      .auto_mode         (held_auto),
      .motor_on          (held_motor),
      .speed_percent     (held_speed)
   );

   // Result packing.
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tdata  = {4'b0000, rsp_speed_ff, rsp_motor_ff, rsp_auto_ff,
                        rsp_rot_ff, rsp_lin_ff, rsp_value_ff, rsp_index_ff};

   // Checks on the sequencer.
   `PPM_ASSERT_ALWAYS(a_pulse_bound, clock, reset, pulse_ff <= PCW'(MAX_CHANNELS))
   `PPM_ASSERT_IMPL(a_div_done_in_divide, clock, reset, div_done, state_ff == ST_DIVIDE)
   `PPM_ASSERT_IMPL(a_rsp_from_emit, clock, reset, $rose(rsp_tvalid_ff), $past(state_ff) == ST_EMIT)
   `PPM_ASSERT_NEXT(a_read_on_sync, clock, reset, state_ff == ST_WRITE, (state_ff == ST_READ) == sync_ff)

endmodule
